@@ sv/mvn_pkg.sv @@
// ----------------------------------------------------------------------------
// mvn_pkg: shared types and constants of the mesh vertex normal engine
// Item and result layouts, state encodings, controller commands and status,
// multiplier operand tables and the saturating normal-sum adder.
// ----------------------------------------------------------------------------
package mvn_pkg;

    localparam int NUM_VERT = 64;
    localparam int VIDX_W   = 6;
    localparam int FACE_W   = 10;
    localparam int POS_W    = 16;
    localparam int DIFF_W   = 17;
    localparam int PROD_W   = 34;
    localparam int CROSS_W  = 35;
    localparam int SUM_W    = 24;
    localparam int NORM_W   = 16;
    localparam int CNT_W    = 7;
    localparam int SMAG_W   = 30;
    localparam int SQ_W     = 60;
    localparam int S_W      = 62;
    localparam int ROOT_W   = 31;
    localparam int DEN_W    = 32;
    localparam int QUO_W    = 15;
    localparam int NUM_W    = 46;
    localparam int NCNT_W   = 5;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_FACE   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic KIND_FACE = 1'b0;
    localparam logic KIND_VERT = 1'b1;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(NUM_VERT);

    localparam logic signed [SUM_W:0] SUM_HI = 25'sd8388607;
    localparam logic signed [SUM_W:0] SUM_LO = -25'sd8388608;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [VIDX_W-1:0]       vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [VIDX_W-1:0]       corner_a;
        logic [VIDX_W-1:0]       corner_b;
        logic [VIDX_W-1:0]       corner_c;
    } req_t;

    typedef struct packed {
        logic                     normal_kind;
        logic [FACE_W-1:0]        item_index;
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic                     degenerate;
        logic                     last_of_run;
    } rsp_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } pos_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] sz;
    } sum_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FRD_A,
        S_FRD_B,
        S_FRD_C,
        S_FCAP,
        S_FMUL,
        S_FNST,
        S_FNORM,
        S_FUPD_RD,
        S_FUPD_WR,
        S_FOUT,
        S_VRD,
        S_VCAP,
        S_VNORM,
        S_VOUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_CHK,
        N_SQRT,
        N_DINIT,
        N_DIV,
        N_DONE
    } norm_state_t;

    typedef struct packed {
        logic       latch_item;
        logic       pos_wr;
        logic       pos_rd;
        logic       pos_cap;
        logic [1:0] cap_corner;
        logic [1:0] corner;
        logic       mul_clr;
        logic       mul_step;
        logic       norm_start;
        logic       norm_vert;
        logic       sum_rd;
        logic       sum_vert;
        logic       sum_wr;
        logic       vcnt_clr;
        logic       vcnt_inc;
        logic       out_face;
        logic       out_vert;
        logic       fcnt_inc;
        logic       finish_clr;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic norm_done;
        logic norm_deg;
        logic vcnt_last;
        logic out_free;
    } stat_t;

    // cross product term k uses d1[sel_a] * d2[sel_b]
    function automatic logic [1:0] mul_sel_a(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0:    r = 2'd1;
            3'd1:    r = 2'd2;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd0;
            3'd4:    r = 2'd0;
            3'd5:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] mul_sel_b(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0:    r = 2'd2;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd0;
            3'd3:    r = 2'd2;
            3'd4:    r = 2'd1;
            3'd5:    r = 2'd0;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  a,
        input logic signed [NORM_W-1:0] b
    );
        logic signed [SUM_W:0] t;
        t = (SUM_W+1)'(a) + (SUM_W+1)'(b);
        if (t > SUM_HI)
            return SUM_HI[SUM_W-1:0];
        else if (t < SUM_LO)
            return SUM_LO[SUM_W-1:0];
        else
            return t[SUM_W-1:0];
    endfunction

endpackage

@@ sv/mvn_ram.sv @@
// ----------------------------------------------------------------------------
// mvn_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/mvn_norm.sv @@
// ----------------------------------------------------------------------------
// mvn_norm: vector normalizer
// Scales a signed vector to unit length in Q1.14: range reduction, sum of
// squares on one multiplier, bit-serial square root, then three restoring
// divides in parallel, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mvn_norm (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [mvn_pkg::CROSS_W-1:0]    vec_x,
    input  logic signed [mvn_pkg::CROSS_W-1:0]    vec_y,
    input  logic signed [mvn_pkg::CROSS_W-1:0]    vec_z,
    output logic                                  done,
    output logic                                  deg,
    output logic signed [mvn_pkg::NORM_W-1:0]     nx,
    output logic signed [mvn_pkg::NORM_W-1:0]     ny,
    output logic signed [mvn_pkg::NORM_W-1:0]     nz
);

    mvn_pkg::norm_state_t state_reg, state_next;

    logic [mvn_pkg::CROSS_W-1:0] mag_reg [3];
    logic [2:0]                  neg_reg;
    logic [mvn_pkg::SQ_W-1:0]    prod_reg;
    logic [mvn_pkg::S_W-1:0]     s_reg;
    logic [mvn_pkg::S_W-1:0]     bit_reg;
    logic [mvn_pkg::S_W-1:0]     res_reg;
    logic [mvn_pkg::NUM_W-1:0]   rem_reg [3];
    logic [mvn_pkg::NUM_W-1:0]   dsh_reg;
    logic [mvn_pkg::QUO_W-1:0]   q_reg [3];
    logic [mvn_pkg::NCNT_W-1:0]  cnt_reg;
    logic                        deg_reg;

    logic [mvn_pkg::CROSS_W-1:0] mx;
    logic [2:0]                  sh;
    logic [mvn_pkg::SMAG_W-1:0]  sq_op;
    logic [mvn_pkg::S_W-1:0]     trial;
    logic [mvn_pkg::DEN_W-1:0]   den;

    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx)
            mx = mag_reg[1];
        if (mag_reg[2] > mx)
            mx = mag_reg[2];
        if (mx[34])
            sh = 3'd5;
        else if (mx[33])
            sh = 3'd4;
        else if (mx[32])
            sh = 3'd3;
        else if (mx[31])
            sh = 3'd2;
        else if (mx[30])
            sh = 3'd1;
        else
            sh = 3'd0;
    end

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    sq_op = mag_reg[0][mvn_pkg::SMAG_W-1:0];
            2'd1:    sq_op = mag_reg[1][mvn_pkg::SMAG_W-1:0];
            default: sq_op = mag_reg[2][mvn_pkg::SMAG_W-1:0];
        endcase
    end

    assign trial = res_reg + bit_reg;
    assign den   = {res_reg[mvn_pkg::ROOT_W-1:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvn_pkg::N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mvn_pkg::N_IDLE:  if (start) state_next = mvn_pkg::N_SHIFT;
            mvn_pkg::N_SHIFT: state_next = mvn_pkg::N_SQ;
            mvn_pkg::N_SQ:    if (cnt_reg == 5'd3) state_next = mvn_pkg::N_CHK;
            mvn_pkg::N_CHK:
            begin
                if (s_reg == '0)
                    state_next = mvn_pkg::N_DONE;
                else
                    state_next = mvn_pkg::N_SQRT;
            end
            mvn_pkg::N_SQRT:  if (cnt_reg == 5'd30) state_next = mvn_pkg::N_DINIT;
            mvn_pkg::N_DINIT: state_next = mvn_pkg::N_DIV;
            mvn_pkg::N_DIV:   if (cnt_reg == 5'd14) state_next = mvn_pkg::N_DONE;
            mvn_pkg::N_DONE:  state_next = mvn_pkg::N_IDLE;
            default:          state_next = mvn_pkg::N_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            mvn_pkg::N_IDLE:
            begin
                if (start)
                begin
                    mag_reg[0] <= vec_x[mvn_pkg::CROSS_W-1] ? -vec_x : vec_x;
                    mag_reg[1] <= vec_y[mvn_pkg::CROSS_W-1] ? -vec_y : vec_y;
                    mag_reg[2] <= vec_z[mvn_pkg::CROSS_W-1] ? -vec_z : vec_z;
                    neg_reg    <= {vec_z[mvn_pkg::CROSS_W-1], vec_y[mvn_pkg::CROSS_W-1],
                                   vec_x[mvn_pkg::CROSS_W-1]};
                end
            end
            mvn_pkg::N_SHIFT:
            begin
                // bring the largest magnitude below 2^30
                for (int i = 0; i < 3; i++)
                    mag_reg[i] <= mag_reg[i] >> sh;
                cnt_reg <= '0;
                s_reg   <= '0;
            end
            mvn_pkg::N_SQ:
            begin
                if (cnt_reg != 5'd3)
                    prod_reg <= mvn_pkg::SQ_W'(sq_op) * mvn_pkg::SQ_W'(sq_op);
                if (cnt_reg != 5'd0)
                    s_reg <= s_reg + mvn_pkg::S_W'(prod_reg);
                cnt_reg <= cnt_reg + 5'd1;
            end
            mvn_pkg::N_CHK:
            begin
                deg_reg <= (s_reg == '0);
                for (int i = 0; i < 3; i++)
                    q_reg[i] <= '0;
                bit_reg <= {2'b01, {(mvn_pkg::S_W-2){1'b0}}};
                res_reg <= '0;
                cnt_reg <= '0;
            end
            mvn_pkg::N_SQRT:
            begin
                if (s_reg >= trial)
                begin
                    s_reg   <= s_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 5'd1;
            end
            mvn_pkg::N_DINIT:
            begin
                dsh_reg <= {den, {(mvn_pkg::QUO_W-1){1'b0}}};
                for (int i = 0; i < 3; i++)
                    rem_reg[i] <= mvn_pkg::NUM_W'({mag_reg[i][mvn_pkg::SMAG_W-1:0],
                                                   {mvn_pkg::QUO_W{1'b0}}})
                                  + mvn_pkg::NUM_W'(res_reg[mvn_pkg::ROOT_W-1:0]);
                cnt_reg <= '0;
            end
            mvn_pkg::N_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[i] >= dsh_reg)
                    begin
                        rem_reg[i] <= rem_reg[i] - dsh_reg;
                        q_reg[i]   <= {q_reg[i][mvn_pkg::QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q_reg[i] <= {q_reg[i][mvn_pkg::QUO_W-2:0], 1'b0};
                    end
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg + 5'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == mvn_pkg::N_DONE);
    assign deg  = deg_reg;
    assign nx = neg_reg[0] ? -mvn_pkg::NORM_W'(q_reg[0]) : mvn_pkg::NORM_W'(q_reg[0]);
    assign ny = neg_reg[1] ? -mvn_pkg::NORM_W'(q_reg[1]) : mvn_pkg::NORM_W'(q_reg[1]);
    assign nz = neg_reg[2] ? -mvn_pkg::NORM_W'(q_reg[2]) : mvn_pkg::NORM_W'(q_reg[2]);

endmodule

@@ sv/mvn_dp.sv @@
// ----------------------------------------------------------------------------
// mvn_dp: datapath of the mesh vertex normal engine
// Position and normal-sum memories, cross product on one multiplier, the
// normalizer, counters, configuration register and the result register.
// ----------------------------------------------------------------------------
module mvn_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mvn_pkg::cmd_t             cmd,
    output mvn_pkg::stat_t            stat,
    input  mvn_pkg::req_t             req_data,
    input  logic                      cfg_write,
    input  logic [mvn_pkg::CNT_W-1:0] cfg_data,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output mvn_pkg::rsp_t             rsp_data
);

    logic [mvn_pkg::CNT_W-1:0]         vc_reg;
    logic [mvn_pkg::VIDX_W-1:0]        corner_reg [3];
    logic signed [mvn_pkg::POS_W-1:0]  pos_reg [3][3];
    logic signed [mvn_pkg::DIFF_W-1:0] d1_reg [3];
    logic signed [mvn_pkg::DIFF_W-1:0] d2_reg [3];
    logic signed [mvn_pkg::PROD_W-1:0] prod_reg;
    logic signed [mvn_pkg::CROSS_W-1:0] cr_reg [3];
    logic [2:0]                        mcnt_reg;
    logic [mvn_pkg::FACE_W-1:0]        fcnt_reg;
    logic [mvn_pkg::VIDX_W-1:0]        vcnt_reg;
    logic [mvn_pkg::NUM_VERT-1:0]      valid_reg;
    logic [mvn_pkg::VIDX_W-1:0]        sum_addr_reg;
    logic                              rsp_valid_reg;
    mvn_pkg::rsp_t                     rsp_data_reg;

    logic [mvn_pkg::VIDX_W-1:0] sel_corner;
    logic [mvn_pkg::VIDX_W-1:0] vc_last;
    logic [mvn_pkg::VIDX_W-1:0] sum_raddr;
    mvn_pkg::pos_t              pos_wdata;
    mvn_pkg::pos_t              pos_rdata;
    mvn_pkg::sum_t              sum_rdata;
    mvn_pkg::sum_t              sum_cur;
    mvn_pkg::sum_t              sum_wdata;
    logic [2:0]                 mk;
    logic [2:0]                 cj;
    logic [1:0]                 sa;
    logic [1:0]                 sb;
    logic                       out_free;

    logic signed [mvn_pkg::CROSS_W-1:0] nvec_x;
    logic signed [mvn_pkg::CROSS_W-1:0] nvec_y;
    logic signed [mvn_pkg::CROSS_W-1:0] nvec_z;
    logic                               n_done;
    logic                               n_deg;
    logic signed [mvn_pkg::NORM_W-1:0]  n_x;
    logic signed [mvn_pkg::NORM_W-1:0]  n_y;
    logic signed [mvn_pkg::NORM_W-1:0]  n_z;

    always_comb
    begin
        case (cmd.corner)
            2'd1:    sel_corner = corner_reg[1];
            2'd2:    sel_corner = corner_reg[2];
            default: sel_corner = corner_reg[0];
        endcase
    end

    // zero counts as one vertex, anything above the table as a full table
    always_comb
    begin
        if (vc_reg == '0)
            vc_last = '0;
        else if (vc_reg > mvn_pkg::CNT_W'(mvn_pkg::NUM_VERT))
            vc_last = mvn_pkg::VIDX_W'(mvn_pkg::NUM_VERT - 1);
        else
            vc_last = mvn_pkg::VIDX_W'(vc_reg - 7'd1);
    end

    assign pos_wdata = '{x: req_data.pos_x, y: req_data.pos_y, z: req_data.pos_z};
    assign sum_raddr = cmd.sum_vert ? vcnt_reg : sel_corner;

    mvn_ram #(
        .WIDTH (3 * mvn_pkg::POS_W),
        .DEPTH (mvn_pkg::NUM_VERT)
    ) u_pos_ram (
        .clk   (clk),
        .we    (cmd.pos_wr),
        .waddr (req_data.vertex_index),
        .wdata (pos_wdata),
        .re    (cmd.pos_rd),
        .raddr (sel_corner),
        .rdata (pos_rdata)
    );

    mvn_ram #(
        .WIDTH (3 * mvn_pkg::SUM_W),
        .DEPTH (mvn_pkg::NUM_VERT)
    ) u_sum_ram (
        .clk   (clk),
        .we    (cmd.sum_wr),
        .waddr (sel_corner),
        .wdata (sum_wdata),
        .re    (cmd.sum_rd),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    // an entry not written since the last finish reads as zero
    assign sum_cur = valid_reg[sum_addr_reg] ? sum_rdata : '0;

    assign sum_wdata = '{sx: mvn_pkg::sat_add(sum_cur.sx, n_x),
                         sy: mvn_pkg::sat_add(sum_cur.sy, n_y),
                         sz: mvn_pkg::sat_add(sum_cur.sz, n_z)};

    assign mk = mcnt_reg - 3'd1;
    assign cj = mcnt_reg - 3'd2;
    assign sa = mvn_pkg::mul_sel_a(mk);
    assign sb = mvn_pkg::mul_sel_b(mk);

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            corner_reg[0] <= req_data.corner_a;
            corner_reg[1] <= req_data.corner_b;
            corner_reg[2] <= req_data.corner_c;
        end
        if (cmd.pos_cap)
        begin
            case (cmd.cap_corner)
                2'd1:
                begin
                    pos_reg[1][0] <= pos_rdata.x;
                    pos_reg[1][1] <= pos_rdata.y;
                    pos_reg[1][2] <= pos_rdata.z;
                end
                2'd2:
                begin
                    pos_reg[2][0] <= pos_rdata.x;
                    pos_reg[2][1] <= pos_rdata.y;
                    pos_reg[2][2] <= pos_rdata.z;
                end
                default:
                begin
                    pos_reg[0][0] <= pos_rdata.x;
                    pos_reg[0][1] <= pos_rdata.y;
                    pos_reg[0][2] <= pos_rdata.z;
                end
            endcase
        end
        if (cmd.sum_rd)
        begin
            sum_addr_reg <= sum_raddr;
        end
        if (cmd.mul_step)
        begin
            if (mcnt_reg == 3'd0)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d1_reg[i] <= mvn_pkg::DIFF_W'(pos_reg[1][i]) - mvn_pkg::DIFF_W'(pos_reg[0][i]);
                    d2_reg[i] <= mvn_pkg::DIFF_W'(pos_reg[2][i]) - mvn_pkg::DIFF_W'(pos_reg[0][i]);
                end
            end
            if (mcnt_reg >= 3'd1 && mcnt_reg <= 3'd6)
            begin
                prod_reg <= d1_reg[sa] * d2_reg[sb];
            end
            if (mcnt_reg >= 3'd2)
            begin
                if (!cj[0])
                    cr_reg[cj[2:1]] <= mvn_pkg::CROSS_W'(prod_reg);
                else
                    cr_reg[cj[2:1]] <= cr_reg[cj[2:1]] - mvn_pkg::CROSS_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg        <= mvn_pkg::VCOUNT_RESET;
            mcnt_reg      <= '0;
            fcnt_reg      <= '0;
            vcnt_reg      <= '0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                vc_reg <= cfg_data;
            if (cmd.mul_clr)
                mcnt_reg <= '0;
            else if (cmd.mul_step)
                mcnt_reg <= mcnt_reg + 3'd1;
            if (cmd.finish_clr)
                fcnt_reg <= '0;
            else if (cmd.fcnt_inc)
                fcnt_reg <= fcnt_reg + 10'd1;
            if (cmd.vcnt_clr)
                vcnt_reg <= '0;
            else if (cmd.vcnt_inc)
                vcnt_reg <= vcnt_reg + 6'd1;
            if (cmd.finish_clr)
                valid_reg <= '0;
            else if (cmd.sum_wr)
                valid_reg[sel_corner] <= 1'b1;
            if (cmd.out_face || cmd.out_vert)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_face || cmd.out_vert)
        begin
            rsp_data_reg.normal_kind <= cmd.out_vert ? mvn_pkg::KIND_VERT : mvn_pkg::KIND_FACE;
            rsp_data_reg.item_index  <= cmd.out_vert ? mvn_pkg::FACE_W'(vcnt_reg) : fcnt_reg;
            rsp_data_reg.norm_x      <= n_x;
            rsp_data_reg.norm_y      <= n_y;
            rsp_data_reg.norm_z      <= n_z;
            rsp_data_reg.degenerate  <= n_deg;
            rsp_data_reg.last_of_run <= cmd.out_vert && (vcnt_reg == vc_last);
        end
    end

    assign nvec_x = cmd.norm_vert ? mvn_pkg::CROSS_W'(sum_cur.sx) : cr_reg[0];
    assign nvec_y = cmd.norm_vert ? mvn_pkg::CROSS_W'(sum_cur.sy) : cr_reg[1];
    assign nvec_z = cmd.norm_vert ? mvn_pkg::CROSS_W'(sum_cur.sz) : cr_reg[2];

    mvn_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.norm_start),
        .vec_x (nvec_x),
        .vec_y (nvec_y),
        .vec_z (nvec_z),
        .done  (n_done),
        .deg   (n_deg),
        .nx    (n_x),
        .ny    (n_y),
        .nz    (n_z)
    );

    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign stat = '{mul_done:  (mcnt_reg == 3'd7),
                    norm_done: n_done,
                    norm_deg:  n_deg,
                    vcnt_last: (vcnt_reg == vc_last),
                    out_free:  out_free};

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

@@ sv/mvn_ctrl.sv @@
// ----------------------------------------------------------------------------
// mvn_ctrl: controller of the mesh vertex normal engine
// Sequences vertex loads, face processing and the finish walk over the
// vertex table by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module mvn_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic [1:0]     opcode,
    output logic           req_stall,
    output mvn_pkg::cmd_t  cmd,
    input  mvn_pkg::stat_t stat
);

    mvn_pkg::ctrl_state_t state_reg, state_next;
    logic [1:0]           corner_reg, corner_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mvn_pkg::S_IDLE;
            corner_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        cmd         = '0;
        req_stall   = (state_reg != mvn_pkg::S_IDLE);
        case (state_reg)
            mvn_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch_item = 1'b1;
                    case (opcode)
                        mvn_pkg::OP_LOAD:   cmd.pos_wr = 1'b1;
                        mvn_pkg::OP_FACE:   state_next = mvn_pkg::S_FRD_A;
                        mvn_pkg::OP_FINISH:
                        begin
                            cmd.vcnt_clr = 1'b1;
                            state_next   = mvn_pkg::S_VRD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            mvn_pkg::S_FRD_A:
            begin
                cmd.pos_rd = 1'b1;
                cmd.corner = 2'd0;
                state_next = mvn_pkg::S_FRD_B;
            end
            mvn_pkg::S_FRD_B:
            begin
                cmd.pos_rd     = 1'b1;
                cmd.corner     = 2'd1;
                cmd.pos_cap    = 1'b1;
                cmd.cap_corner = 2'd0;
                state_next     = mvn_pkg::S_FRD_C;
            end
            mvn_pkg::S_FRD_C:
            begin
                cmd.pos_rd     = 1'b1;
                cmd.corner     = 2'd2;
                cmd.pos_cap    = 1'b1;
                cmd.cap_corner = 2'd1;
                state_next     = mvn_pkg::S_FCAP;
            end
            mvn_pkg::S_FCAP:
            begin
                cmd.pos_cap    = 1'b1;
                cmd.cap_corner = 2'd2;
                cmd.mul_clr    = 1'b1;
                state_next     = mvn_pkg::S_FMUL;
            end
            mvn_pkg::S_FMUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_done)
                    state_next = mvn_pkg::S_FNST;
            end
            mvn_pkg::S_FNST:
            begin
                cmd.norm_start = 1'b1;
                state_next     = mvn_pkg::S_FNORM;
            end
            mvn_pkg::S_FNORM:
            begin
                if (stat.norm_done)
                begin
                    // a zero normal leaves the corner sums alone
                    corner_next = 2'd0;
                    state_next  = stat.norm_deg ? mvn_pkg::S_FOUT : mvn_pkg::S_FUPD_RD;
                end
            end
            mvn_pkg::S_FUPD_RD:
            begin
                cmd.sum_rd = 1'b1;
                cmd.corner = corner_reg;
                state_next = mvn_pkg::S_FUPD_WR;
            end
            mvn_pkg::S_FUPD_WR:
            begin
                cmd.sum_wr = 1'b1;
                cmd.corner = corner_reg;
                if (corner_reg == 2'd2)
                begin
                    state_next = mvn_pkg::S_FOUT;
                end
                else
                begin
                    corner_next = corner_reg + 2'd1;
                    state_next  = mvn_pkg::S_FUPD_RD;
                end
            end
            mvn_pkg::S_FOUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_face = 1'b1;
                    cmd.fcnt_inc = 1'b1;
                    state_next   = mvn_pkg::S_IDLE;
                end
            end
            mvn_pkg::S_VRD:
            begin
                cmd.sum_rd   = 1'b1;
                cmd.sum_vert = 1'b1;
                state_next   = mvn_pkg::S_VCAP;
            end
            mvn_pkg::S_VCAP:
            begin
                cmd.norm_start = 1'b1;
                cmd.norm_vert  = 1'b1;
                state_next     = mvn_pkg::S_VNORM;
            end
            mvn_pkg::S_VNORM:
            begin
                if (stat.norm_done)
                    state_next = mvn_pkg::S_VOUT;
            end
            mvn_pkg::S_VOUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_vert = 1'b1;
                    if (stat.vcnt_last)
                    begin
                        cmd.finish_clr = 1'b1;
                        state_next     = mvn_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.vcnt_inc = 1'b1;
                        state_next   = mvn_pkg::S_VRD;
                    end
                end
            end
            default:
            begin
                state_next = mvn_pkg::S_IDLE;
            end
        endcase
    end

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_face || cmd.out_vert) |-> stat.out_free)
        else $error("result loaded while result register occupied");

    a_face_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mvn_pkg::S_IDLE && req_valid && opcode == mvn_pkg::OP_FACE)
        |=> (state_reg == mvn_pkg::S_FRD_A))
        else $error("face transfer did not start corner reads");

    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish_clr |-> (cmd.out_vert && stat.vcnt_last))
        else $error("sums cleared before last vertex normal");

    a_norm_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.norm_start |=> !stat.norm_done)
        else $error("normalizer finished too early");

endmodule

@@ sv/mesh_vertex_normal_engine.sv @@
// ----------------------------------------------------------------------------
// mesh_vertex_normal_engine: smooth vertex normals from face cross products
// Load items fill the vertex table, face items emit a unit face normal and
// accumulate it into the corner sums, finish items emit all vertex normals.
// ----------------------------------------------------------------------------
// Load: written to the vertex table when taken. Face: time to the result is
// set by the normalizer (31-step square root, 15-step divides) plus 3 corner
// reads, 8 multiply steps and 3 read-modify-write sum updates, which a zero
// normal skips. Finish: one normal per vertex in use; output stalls add.
// One item is worked on at a time; the result register frees the input side.
// Reset (rst_n, async, active low) clears sums, face count and controls;
// vertex_count resets to 64, vertex positions are undefined until loaded.
module mesh_vertex_normal_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  mvn_pkg::req_t             req_data,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output mvn_pkg::rsp_t             rsp_data,
    input  logic                      cfg_write,
    input  logic [mvn_pkg::CNT_W-1:0] cfg_data
);

    mvn_pkg::cmd_t  cmd;
    mvn_pkg::stat_t stat;

    mvn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .opcode    (req_data.opcode),
        .req_stall (req_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    mvn_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req_data  (req_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule
